FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/tdq_pkg.sv
`default_nettype none
package tdq_pkg;
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FND  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam int TIME_W = 48;
    localparam int KEY_W  = 32;
    localparam int MAX_RESULTS = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] key;
        logic             expired;
        logic             last;
    } result_t;
endpackage
`default_nettype wire

FILE: hdl/tdq_slot_mem.sv
`default_nettype none
module tdq_slot_mem
    import tdq_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int AW = 6
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [KEY_W+TIME_W-1:0]  wdata,
    input  wire logic [AW-1:0]            raddr,
    output logic      [KEY_W+TIME_W-1:0]  rdata
);
    logic [KEY_W+TIME_W-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/timer_deadline_queue_unit.sv
// Operation: add, remove and tick each scan the slot memory, one slot per cycle, then
// emit a result; a tick scans again for each further expired timer, up to the limit.
// A tick with a limit of zero answers the cycle after accept.
// Flow: one item at a time; the next transaction is taken the cycle after the last result
// is accepted.
// Reset: valid flags (flip-flops) clear at once, next key 0, limit 64; no clearing pass.
`default_nettype none
module timer_deadline_queue_unit
    import tdq_pkg::*;
#(
    parameter int TIMER_SLOTS = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind[1:0]
    input  wire logic [1:0]   s_tuser,
    // time_now[47:0], delay_ms[79:48], timer_key[111:80]
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], result_key[33:2]
    output logic [39:0]       m_tdata,
    // expired[0]
    output logic              m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [6:0]   cfg_data
);
    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = AW + 1;

    state_t state_reg, state_next;
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [KEY_W-1:0] next_key_reg, next_key_next;
    logic [6:0] max_reg;
    logic [1:0] kind_reg, kind_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [KEY_W-1:0] delay_reg, delay_next, key_reg, key_next;
    logic [CW-1:0] idx_reg, idx_next;      // address presented this cycle
    logic [AW-1:0] cur_reg, cur_next;      // address of rdata
    logic cur_ok_reg, cur_ok_next;
    logic found_reg, found_next;
    logic multi_reg, multi_next;           // a second due timer seen in this scan
    logic [AW-1:0] best_reg, best_next;
    logic [KEY_W-1:0] bkey_reg, bkey_next;
    logic [TIME_W-1:0] bdl_reg, bdl_next;
    logic [6:0] cnt_reg, cnt_next;
    result_t out_reg, out_next;
    logic ov_reg, ov_next;

    logic we;
    logic [AW-1:0] waddr;
    logic [KEY_W+TIME_W-1:0] wdata, rdata;
    logic [KEY_W-1:0] r_key;
    logic [TIME_W-1:0] r_dl;
    logic [TIME_W:0] sum;
    logic [6:0] limit;
    logic better;
    logic tick_done;

    assign r_key = rdata[KEY_W+TIME_W-1:TIME_W];
    assign r_dl  = rdata[TIME_W-1:0];
    assign sum = {1'b0, now_reg} + {{(TIME_W-KEY_W+1){1'b0}}, delay_reg};
    assign limit = (max_reg > 7'd64) ? 7'd64 : max_reg;
    assign better = !found_reg || (r_dl < bdl_reg) ||
                    (r_dl == bdl_reg && r_key < bkey_reg);
    assign tick_done = !multi_reg || (cnt_reg + 7'd1 >= limit);

    tdq_slot_mem #(.SLOTS(TIMER_SLOTS), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rdata)
    );

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = ov_reg;
    assign m_tdata = {6'd0, out_reg.key, out_reg.status};
    assign m_tuser = out_reg.expired;
    assign m_tlast = out_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            next_key_reg <= '0;
            max_reg <= 7'd64;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            next_key_reg <= next_key_next;
            ov_reg <= ov_next;
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        now_reg <= now_next;
        delay_reg <= delay_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        cur_ok_reg <= cur_ok_next;
        found_reg <= found_next;
        multi_reg <= multi_next;
        best_reg <= best_next;
        bkey_reg <= bkey_next;
        bdl_reg <= bdl_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        next_key_next = next_key_reg;
        kind_next = kind_reg;
        now_next = now_reg;
        delay_next = delay_reg;
        key_next = key_reg;
        idx_next = idx_reg;
        cur_next = cur_reg;
        cur_ok_next = 1'b0;
        found_next = found_reg;
        multi_next = multi_reg;
        best_next = best_reg;
        bkey_next = bkey_reg;
        bdl_next = bdl_reg;
        cnt_next = cnt_reg;
        out_next = out_reg;
        ov_next = ov_reg && !m_tready;
        we = 1'b0;
        waddr = best_reg;
        wdata = {next_key_reg, sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0]};
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready && s_tuser != KIND_UNUSED)
                begin
                    kind_next = s_tuser;
                    now_next = s_tdata[47:0];
                    delay_next = s_tdata[79:48];
                    key_next = s_tdata[111:80];
                    idx_next = '0;
                    found_next = 1'b0;
                    multi_next = 1'b0;
                    cnt_next = '0;
                    if (s_tuser == KIND_TICK && limit == 7'd0)
                    begin
                        out_next = '{ST_NONE, '0, 1'b0, 1'b1};
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN, S_LAST:
            begin
                // judge slot read last cycle
                if (cur_ok_reg && valid_reg[cur_reg] && !found_reg)
                begin
                    if (kind_reg == KIND_REMOVE && r_key == key_reg)
                    begin
                        found_next = 1'b1;
                        best_next = cur_reg;
                    end
                end
                if (cur_ok_reg && valid_reg[cur_reg] && kind_reg == KIND_TICK &&
                    r_dl <= now_reg && found_reg)
                begin
                    multi_next = 1'b1;
                end
                if (cur_ok_reg && valid_reg[cur_reg] && kind_reg == KIND_TICK &&
                    r_dl <= now_reg && better)
                begin
                    found_next = 1'b1;
                    best_next = cur_reg;
                    bkey_next = r_key;
                    bdl_next = r_dl;
                end
                if (kind_reg == KIND_ADD && state_reg == S_SCAN && !found_reg &&
                    !valid_reg[idx_reg[AW-1:0]])
                begin
                    found_next = 1'b1;
                    best_next = idx_reg[AW-1:0];
                end
                if (state_reg == S_SCAN)
                begin
                    cur_next = idx_reg[AW-1:0];
                    cur_ok_next = 1'b1;
                    if (idx_reg == CW'(TIMER_SLOTS - 1))
                    begin
                        state_next = S_LAST;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                    unique case (kind_reg)
                        KIND_ADD:
                        begin
                            if (found_reg)
                            begin
                                we = 1'b1;
                                valid_next[best_reg] = 1'b1;
                                out_next = '{ST_OK, next_key_reg, 1'b0, 1'b1};
                                next_key_next = next_key_reg + 1'b1;
                            end
                            else
                            begin
                                out_next = '{ST_FULL, '0, 1'b0, 1'b1};
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                valid_next[best_reg] = 1'b0;
                            end
                            out_next = '{found_reg ? ST_OK : ST_NOT_FND, key_reg,
                                         1'b0, 1'b1};
                        end
                        default:
                        begin
                            // a later scan only follows when another timer is due
                            if (!found_reg)
                            begin
                                out_next = '{ST_NONE, '0, 1'b0, 1'b1};
                            end
                            else
                            begin
                                valid_next[best_reg] = 1'b0;
                                out_next = '{ST_OK, bkey_reg, 1'b1, tick_done};
                                cnt_next = cnt_reg + 7'd1;
                                if (!tick_done)
                                begin
                                    found_next = 1'b0;
                                    multi_next = 1'b0;
                                    idx_next = '0;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/tdq_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tdq_checker
    import tdq_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    `ASSERT_NEXT(out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `ASSERT_IMPL(no_accept_busy, m_tvalid, !s_tready)
    `ASSERT_IMPL(nonexp_last, m_tvalid && !m_tuser, m_tlast)
    `ASSERT_IMPL(exp_ok, m_tvalid && m_tuser, m_tdata[1:0] == ST_OK)
endmodule

bind timer_deadline_queue_unit tdq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
);
`default_nettype wire
